// ===== hw/rtl/countdown_timer_with_status_led_unit_assert.svh =====
// Assertion macros for the countdown timer checker.
`ifndef COUNTDOWN_TIMER_WITH_STATUS_LED_UNIT_ASSERT_SVH
`define COUNTDOWN_TIMER_WITH_STATUS_LED_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CDT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("countdown timer check failed");

// Next-cycle implication, disabled while in reset.
`define CDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("countdown timer check failed");

`endif

// ===== hw/rtl/cdt_pkg.sv =====
// Types, constants and helpers for the countdown timer with status light.
package cdt_pkg;

    localparam int SECONDS_WIDTH    = 16;
    localparam int MS_COUNTER_WIDTH = 16;

    localparam logic [31:0] SEC_MAX =
        32'((64'd1 << SECONDS_WIDTH) - 64'd1);
    localparam logic [31:0] MS_MAX =
        32'((64'd1 << MS_COUNTER_WIDTH) - 64'd1);

    typedef logic [SECONDS_WIDTH-1:0]    sec_t;
    typedef logic [MS_COUNTER_WIDTH-1:0] ms_t;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_PAUSE = 2'd2;
    localparam logic [1:0] MODE_RESET = 2'd3;

    localparam logic [2:0] TS_WAIT  = 3'd0;
    localparam logic [2:0] TS_COUNT = 3'd1;
    localparam logic [2:0] TS_PAUSE = 3'd2;
    localparam logic [2:0] TS_END   = 3'd3;
    localparam logic [2:0] TS_DONE  = 3'd4;

    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_SECOND       = 3'd1;
    localparam logic [2:0] REG_WAIT_BLINK   = 3'd2;
    localparam logic [2:0] REG_END_BLINK    = 3'd3;
    localparam logic [2:0] REG_BLINK_COUNT  = 3'd4;

    typedef enum logic [4:0] {
        ST_WAIT  = 5'b00001,
        ST_COUNT = 5'b00010,
        ST_PAUSE = 5'b00100,
        ST_END   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] start_seconds;
        logic        button_level;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  timer_state;
        logic [15:0] seconds_left;
        logic        red_on;
        logic        green_on;
        logic        blue_on;
    } out_item_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] second_period_ms;
        logic [15:0] wait_blink_ms;
        logic [15:0] end_blink_ms;
        logic [7:0]  end_blink_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_ms:      16'd200,
        second_period_ms: 16'd1000,
        wait_blink_ms:    16'd500,
        end_blink_ms:     16'd250,
        end_blink_count:  8'd8
    };

    function automatic logic [2:0] state_code(state_t st);
        logic [2:0] code;
        case (st)
            ST_WAIT:  code = TS_WAIT;
            ST_COUNT: code = TS_COUNT;
            ST_PAUSE: code = TS_PAUSE;
            ST_END:   code = TS_END;
            ST_DONE:  code = TS_DONE;
            default:  code = TS_WAIT;
        endcase
        return code;
    endfunction

    function automatic sec_t sat_seconds(logic [15:0] s);
        logic [31:0] w;
        w = 32'(s);
        if (w > SEC_MAX) begin
            return sec_t'(SEC_MAX);
        end
        return sec_t'(w);
    endfunction

    function automatic logic [15:0] report_seconds(sec_t s);
        logic [31:0] w;
        w = 32'(s);
        if (w > 32'h0000_ffff) begin
            return 16'hffff;
        end
        return w[15:0];
    endfunction

endpackage

// ===== hw/rtl/cdt_core.sv =====
// State registers and per-item update of the countdown timer.
module cdt_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  cdt_pkg::in_item_t item,
    input  cdt_pkg::cfg_t     cfg,
    output cdt_pkg::out_item_t result
);
    import cdt_pkg::*;

    localparam logic [2:0] LED_OFF   = 3'b000;
    localparam logic [2:0] LED_R     = 3'b100;
    localparam logic [2:0] LED_G     = 3'b010;
    localparam logic [2:0] LED_B     = 3'b001;
    localparam logic [2:0] LED_WHITE = 3'b111;

    state_t     state_reg, state_next;
    sec_t       remaining_reg, remaining_next;
    ms_t        ms_in_second_reg, ms_in_second_next;
    ms_t        ms_since_blink_reg, ms_since_blink_next;
    ms_t        ms_since_press_reg, ms_since_press_next;
    logic       blink_lit_reg, blink_lit_next;
    logic [7:0] blinks_left_reg, blinks_left_next;
    logic [2:0] led_reg, led_next;
    logic       button_prev_reg, button_prev_next;

    function automatic ms_t sat_inc(ms_t v);
        if (32'(v) >= MS_MAX) begin
            return v;
        end
        return v + ms_t'(1);
    endfunction

    always_comb begin
        state_next          = state_reg;
        remaining_next      = remaining_reg;
        ms_in_second_next   = ms_in_second_reg;
        ms_since_blink_next = ms_since_blink_reg;
        ms_since_press_next = ms_since_press_reg;
        blink_lit_next      = blink_lit_reg;
        blinks_left_next    = blinks_left_reg;
        led_next            = led_reg;
        button_prev_next    = button_prev_reg;
        if (step) begin
            case (item.mode)
                MODE_TICK: begin
                    ms_in_second_next   = sat_inc(ms_in_second_reg);
                    ms_since_blink_next = sat_inc(ms_since_blink_reg);
                    ms_since_press_next = sat_inc(ms_since_press_reg);
                    if (!item.button_level && button_prev_reg) begin
                        if (32'(ms_since_press_next) > 32'(cfg.debounce_ms)) begin
                            ms_since_press_next = '0;
                            if (state_reg == ST_COUNT) begin
                                state_next = ST_PAUSE;
                                led_next   = LED_R;
                            end
                        end
                    end
                    button_prev_next = item.button_level;
                    case (state_next)
                        ST_WAIT: begin
                            if (32'(ms_since_blink_next) >= 32'(cfg.wait_blink_ms)) begin
                                ms_since_blink_next = '0;
                                blink_lit_next      = !blink_lit_reg;
                                led_next = blink_lit_next ? LED_WHITE : LED_OFF;
                            end
                        end
                        ST_COUNT: begin
                            if (32'(ms_in_second_next) >= 32'(cfg.second_period_ms)) begin
                                ms_in_second_next = ms_t'(32'(ms_in_second_next)
                                                          - 32'(cfg.second_period_ms));
                                if (remaining_reg != '0) begin
                                    remaining_next = remaining_reg - sec_t'(1);
                                end
                                if (remaining_next == '0) begin
                                    state_next          = ST_END;
                                    blinks_left_next    = cfg.end_blink_count;
                                    ms_since_blink_next = '0;
                                    blink_lit_next      = 1'b0;
                                end
                            end
                        end
                        ST_END: begin
                            if (32'(ms_since_blink_next) >= 32'(cfg.end_blink_ms)) begin
                                ms_since_blink_next = '0;
                                blink_lit_next      = !blink_lit_reg;
                                led_next = blink_lit_next ? LED_G : LED_OFF;
                                if (!blink_lit_next) begin
                                    if (blinks_left_reg <= 8'd1) begin
                                        blinks_left_next = '0;
                                        state_next       = ST_DONE;
                                        led_next         = LED_B;
                                    end else begin
                                        blinks_left_next = blinks_left_reg - 8'd1;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                MODE_START: begin
                    if (item.start_seconds != '0) begin
                        remaining_next    = sat_seconds(item.start_seconds);
                        state_next        = ST_COUNT;
                        led_next          = LED_WHITE;
                        ms_in_second_next = '0;
                    end
                end
                MODE_PAUSE: begin
                    if (state_reg == ST_COUNT) begin
                        state_next = ST_PAUSE;
                        led_next   = LED_R;
                    end else if (state_reg == ST_PAUSE) begin
                        state_next        = ST_COUNT;
                        led_next          = LED_WHITE;
                        ms_in_second_next = '0;
                    end
                end
                default: begin
                    remaining_next = '0;
                    state_next     = ST_WAIT;
                end
            endcase
        end
    end

    always_comb begin
        result.timer_state  = state_code(state_next);
        result.seconds_left = report_seconds(remaining_next);
        result.red_on       = led_next[2];
        result.green_on     = led_next[1];
        result.blue_on      = led_next[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_WAIT;
            remaining_reg      <= '0;
            ms_in_second_reg   <= '0;
            ms_since_blink_reg <= '0;
            ms_since_press_reg <= '0;
            blink_lit_reg      <= 1'b0;
            blinks_left_reg    <= '0;
            led_reg            <= LED_OFF;
            button_prev_reg    <= 1'b1;
        end else begin
            state_reg          <= state_next;
            remaining_reg      <= remaining_next;
            ms_in_second_reg   <= ms_in_second_next;
            ms_since_blink_reg <= ms_since_blink_next;
            ms_since_press_reg <= ms_since_press_next;
            blink_lit_reg      <= blink_lit_next;
            blinks_left_reg    <= blinks_left_next;
            led_reg            <= led_next;
            button_prev_reg    <= button_prev_next;
        end
    end

endmodule

// ===== hw/rtl/countdown_timer_with_status_led_unit.sv =====
// Top level of the countdown timer with status light.
// An accepted item waits in the input register, updates the timer state and is
// presented from the result register. Throughput: one item per cycle unless the
// result side stalls, set by the single input register feeding the state update.
// Reset: synchronous, active low; clears both stages, the timer state and loads
// the register defaults (200, 1000, 500, 250, 8).
module countdown_timer_with_status_led_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cdt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output cdt_pkg::out_item_t m_item,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wr_data
);
    import cdt_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    in_item_t  in_item_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t out_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t core_result;
    logic      advance;
    logic      step;
    logic      take;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE:    cfg_next.debounce_ms      = cfg_wr_data;
                REG_SECOND:      cfg_next.second_period_ms = cfg_wr_data;
                REG_WAIT_BLINK:  cfg_next.wait_blink_ms    = cfg_wr_data;
                REG_END_BLINK:   cfg_next.end_blink_ms     = cfg_wr_data;
                REG_BLINK_COUNT: cfg_next.end_blink_count  = cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    cdt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_item_reg <= s_item;
        end
        if (step) begin
            out_item_reg <= core_result;
        end
    end

endmodule

// ===== hw/rtl/cdt_checker.sv =====
// Port checker for the countdown timer and its bind to the top level.
`include "countdown_timer_with_status_led_unit_assert.svh"

module cdt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input cdt_pkg::out_item_t m_item
);
    import cdt_pkg::*;

    `CDT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    `CDT_ASSERT_NOW(a_done_blue, aclk, aresetn, m_valid && (m_item.timer_state == TS_DONE), m_item.blue_on && !m_item.red_on && !m_item.green_on)
    `CDT_ASSERT_NOW(a_pause_red, aclk, aresetn, m_valid && (m_item.timer_state == TS_PAUSE), m_item.red_on && !m_item.green_on && !m_item.blue_on)
    `CDT_ASSERT_NOW(a_count_live, aclk, aresetn, m_valid && (m_item.timer_state == TS_COUNT), (m_item.seconds_left != 16'd0) && m_item.red_on && m_item.green_on && m_item.blue_on)

endmodule

bind countdown_timer_with_status_led_unit cdt_checker u_cdt_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the countdown timer with status light.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    localparam logic [2:0] COL_OFF   = 3'b000;
    localparam logic [2:0] COL_RED   = 3'b100;
    localparam logic [2:0] COL_GREEN = 3'b010;
    localparam logic [2:0] COL_BLUE  = 3'b001;
    localparam logic [2:0] COL_WHITE = 3'b111;

    localparam int LONG_HOLD   = 250;
    localparam int SETTLE_CYC  = 8;
    localparam int N_OPENING   = 17;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } probe_t;

    localparam probe_t OPENING_ROWS [N_OPENING] = '{
        '{'{MODE_TICK,  16'd0,     1'b1}, 1'b1, '{TS_WAIT,  16'd0,     1'b0, 1'b0, 1'b0}},
        '{'{MODE_START, 16'd0,     1'b0}, 1'b1, '{TS_WAIT,  16'd0,     1'b0, 1'b0, 1'b0}},
        '{'{MODE_PAUSE, 16'hffff,  1'b1}, 1'b1, '{TS_WAIT,  16'd0,     1'b0, 1'b0, 1'b0}},
        '{'{MODE_RESET, 16'd0,     1'b0}, 1'b1, '{TS_WAIT,  16'd0,     1'b0, 1'b0, 1'b0}},
        '{'{MODE_START, 16'hffff,  1'b1}, 1'b1, '{TS_COUNT, 16'hffff,  1'b1, 1'b1, 1'b1}},
        '{'{MODE_PAUSE, 16'd0,     1'b1}, 1'b1, '{TS_PAUSE, 16'hffff,  1'b1, 1'b0, 1'b0}},
        '{'{MODE_TICK,  16'hffff,  1'b0}, 1'b0, '0},
        '{'{MODE_TICK,  16'd0,     1'b1}, 1'b0, '0},
        '{'{MODE_PAUSE, 16'd0,     1'b0}, 1'b1, '{TS_COUNT, 16'hffff,  1'b1, 1'b1, 1'b1}},
        '{'{MODE_START, 16'd1,     1'b0}, 1'b1, '{TS_COUNT, 16'd1,     1'b1, 1'b1, 1'b1}},
        '{'{MODE_START, 16'haaaa,  1'b1}, 1'b0, '0},
        '{'{MODE_START, 16'h5555,  1'b0}, 1'b0, '0},
        '{'{MODE_TICK,  16'h8000,  1'b0}, 1'b0, '0},
        '{'{MODE_RESET, 16'h7fff,  1'b0}, 1'b1, '{TS_WAIT,  16'd0,     1'b1, 1'b1, 1'b1}},
        '{'{MODE_PAUSE, 16'd0,     1'b1}, 1'b1, '{TS_WAIT,  16'd0,     1'b1, 1'b1, 1'b1}},
        '{'{MODE_TICK,  16'd0,     1'b1}, 1'b0, '0},
        '{'{MODE_START, 16'd1,     1'b1}, 1'b1, '{TS_COUNT, 16'd1,     1'b1, 1'b1, 1'b1}}
    };

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    logic      cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wr_data;

    countdown_timer_with_status_led_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // timer shadow state
    cfg_t       tm_cfg;
    logic [2:0] tm_state;
    sec_t       tm_left;
    ms_t        tm_ms_sec;
    ms_t        tm_ms_blink;
    ms_t        tm_ms_press;
    logic       tm_lit;
    logic [7:0] tm_blinks;
    logic [2:0] tm_colour;
    logic       tm_btn_prev;

    out_item_t  awaited_status [$];
    int         mismatches    = 0;
    int         items_sent    = 0;
    int         steady_items  = 0;
    bit         hold_req      = 1'b0;

    function automatic ms_t ms_bump(ms_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void timer_clear();
        tm_cfg      = CFG_RESET;
        tm_state    = TS_WAIT;
        tm_left     = '0;
        tm_ms_sec   = '0;
        tm_ms_blink = '0;
        tm_ms_press = '0;
        tm_lit      = 1'b0;
        tm_blinks   = '0;
        tm_colour   = COL_OFF;
        tm_btn_prev = 1'b1;
    endfunction

    function automatic out_item_t timer_next(in_item_t it);
        out_item_t r;
        case (it.mode)
            MODE_TICK: begin
                tm_ms_sec   = ms_bump(tm_ms_sec);
                tm_ms_blink = ms_bump(tm_ms_blink);
                tm_ms_press = ms_bump(tm_ms_press);
                if (!it.button_level && tm_btn_prev && tm_ms_press > tm_cfg.debounce_ms) begin
                    tm_ms_press = '0;
                    if (tm_state == TS_COUNT) begin
                        tm_state  = TS_PAUSE;
                        tm_colour = COL_RED;
                    end
                end
                tm_btn_prev = it.button_level;
                case (tm_state)
                    TS_WAIT: begin
                        if (tm_ms_blink >= tm_cfg.wait_blink_ms) begin
                            tm_ms_blink = '0;
                            tm_lit      = ~tm_lit;
                            tm_colour   = tm_lit ? COL_WHITE : COL_OFF;
                        end
                    end
                    TS_COUNT: begin
                        if (tm_ms_sec >= tm_cfg.second_period_ms) begin
                            tm_ms_sec = tm_ms_sec - tm_cfg.second_period_ms;
                            if (tm_left != '0) begin
                                tm_left = tm_left - 1'b1;
                            end
                            if (tm_left == '0) begin
                                tm_state    = TS_END;
                                tm_blinks   = tm_cfg.end_blink_count;
                                tm_ms_blink = '0;
                                tm_lit      = 1'b0;
                            end
                        end
                    end
                    TS_END: begin
                        if (tm_ms_blink >= tm_cfg.end_blink_ms) begin
                            tm_ms_blink = '0;
                            tm_lit      = ~tm_lit;
                            tm_colour   = tm_lit ? COL_GREEN : COL_OFF;
                            if (!tm_lit) begin
                                if (tm_blinks <= 8'd1) begin
                                    tm_blinks = '0;
                                    tm_state  = TS_DONE;
                                    tm_colour = COL_BLUE;
                                end else begin
                                    tm_blinks = tm_blinks - 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_START: begin
                if (it.start_seconds != '0) begin
                    tm_left   = it.start_seconds;
                    tm_state  = TS_COUNT;
                    tm_colour = COL_WHITE;
                    tm_ms_sec = '0;
                end
            end
            MODE_PAUSE: begin
                if (tm_state == TS_COUNT) begin
                    tm_state  = TS_PAUSE;
                    tm_colour = COL_RED;
                end else if (tm_state == TS_PAUSE) begin
                    tm_state  = TS_COUNT;
                    tm_colour = COL_WHITE;
                    tm_ms_sec = '0;
                end
            end
            default: begin
                tm_left  = '0;
                tm_state = TS_WAIT;
            end
        endcase
        r.timer_state  = tm_state;
        r.seconds_left = tm_left;
        r.red_on       = tm_colour[2];
        r.green_on     = tm_colour[1];
        r.blue_on      = tm_colour[0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 50) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic offer_item(input in_item_t it, input logic typed, input out_item_t want);
        int gap;
        out_item_t predicted;
        if (steady_items > 0) begin
            gap = 0;
            steady_items--;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = timer_next(it);
        awaited_status.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic offer_random(input logic [1:0] mode, input logic [15:0] secs,
                                input logic btn);
        in_item_t it;
        it.mode          = mode;
        it.start_seconds = secs;
        it.button_level  = btn;
        offer_item(it, 1'b0, '0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (awaited_status.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_settings(input cfg_t c);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_DEBOUNCE;
        cfg_wr_data <= c.debounce_ms;
        @(negedge aclk);
        cfg_index   <= REG_SECOND;
        cfg_wr_data <= c.second_period_ms;
        @(negedge aclk);
        cfg_index   <= REG_WAIT_BLINK;
        cfg_wr_data <= c.wait_blink_ms;
        @(negedge aclk);
        cfg_index   <= REG_END_BLINK;
        cfg_wr_data <= c.end_blink_ms;
        @(negedge aclk);
        cfg_index   <= REG_BLINK_COUNT;
        cfg_wr_data <= 16'(c.end_blink_count);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tm_cfg = c;
        @(negedge aclk);
    endtask

    // start a countdown and feed ticks, bounces and commands, or send random items
    task automatic run_sessions(input int budget);
        int   stop_at;
        int   ticks;
        int   r;
        logic btn;
        logic [15:0] secs;
        stop_at = items_sent + budget;
        btn = 1'b1;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0) steady_items = $urandom_range(20, 40);
            if ($urandom_range(0, 99) < 85) begin
                secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
                offer_random(MODE_START, secs, 1'($urandom));
                ticks = $urandom_range(8, 90);
                for (int k = 0; k < ticks && items_sent < stop_at; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 4) begin
                        offer_random(MODE_PAUSE, 16'($urandom), 1'($urandom));
                    end else if (r < 6) begin
                        offer_random(MODE_RESET, 16'($urandom), 1'($urandom));
                    end else if (r < 7) begin
                        offer_random(MODE_START, 16'($urandom_range(0, 3)), 1'($urandom));
                    end else begin
                        if ($urandom_range(0, 99) < 7) btn = ~btn;
                        offer_random(MODE_TICK, 16'($urandom), btn);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    offer_random(2'($urandom), 16'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    always @(posedge aclk) begin : status_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_status.size() == 0) begin
                report_mismatch("result with nothing awaited");
            end else begin
                want = awaited_status.pop_front();
                if (m_item.timer_state !== want.timer_state)
                    report_mismatch($sformatf("timer_state %0d, want %0d",
                                              m_item.timer_state, want.timer_state));
                if (m_item.seconds_left !== want.seconds_left)
                    report_mismatch($sformatf("seconds_left %0d, want %0d",
                                              m_item.seconds_left, want.seconds_left));
                if (m_item.red_on !== want.red_on)
                    report_mismatch($sformatf("red_on %b, want %b",
                                              m_item.red_on, want.red_on));
                if (m_item.green_on !== want.green_on)
                    report_mismatch($sformatf("green_on %b, want %b",
                                              m_item.green_on, want.green_on));
                if (m_item.blue_on !== want.blue_on)
                    report_mismatch($sformatf("blue_on %b, want %b",
                                              m_item.blue_on, want.blue_on));
            end
        end
    end

    initial begin : result_sink
        int hold;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12)) @(negedge aclk);
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        cfg_t c;
        s_valid     = 1'b0;
        s_item      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        aresetn     = 1'b0;
        timer_clear();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (OPENING_ROWS[i]) begin
            offer_item(OPENING_ROWS[i].item, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
        end
        run_sessions(60);

        load_settings('{16'd3, 16'd4, 16'd3, 16'd2, 8'd2});
        run_sessions(60);
        // starve the result side while items keep coming
        hold_req = 1'b1;
        steady_items = 80;
        run_sessions(90);

        load_settings('{16'd0, 16'd0, 16'd0, 16'd0, 8'd0});
        run_sessions(120);

        repeat (4) begin
            c.debounce_ms      = 16'($urandom_range(0, 30));
            c.second_period_ms = 16'($urandom_range(1, 10));
            c.wait_blink_ms    = 16'($urandom_range(1, 8));
            c.end_blink_ms     = 16'($urandom_range(1, 6));
            c.end_blink_count  = 8'($urandom_range(1, 5));
            load_settings(c);
            run_sessions(120);
        end

        load_settings('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff});
        run_sessions(60);

        load_settings('{16'd1, 16'd1, 16'd1, 16'd1, 8'd1});
        run_sessions(100);

        load_settings(CFG_RESET);
        run_sessions(60);

        drain();
        repeat (SETTLE_CYC) @(negedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
